### hw/rtl/pio_pkg.sv
// Shared types and constants of the parallel I/O port controller.
// Used by pio_access and by the top level; depends on nothing else.
package pio_pkg;

  localparam int PortCount = 2;

  localparam logic [2:0] KIND_CTRL_WR = 3'd0;
  localparam logic [2:0] KIND_CTRL_RD = 3'd1;
  localparam logic [2:0] KIND_DATA_WR = 3'd2;
  localparam logic [2:0] KIND_DATA_RD = 3'd3;
  localparam logic [2:0] KIND_PIN_UPD = 3'd4;

  localparam logic [1:0] MODE_OUT    = 2'd0;
  localparam logic [1:0] MODE_IN     = 2'd1;
  localparam logic [1:0] MODE_BIDIR  = 2'd2;
  localparam logic [1:0] MODE_BITCTL = 2'd3;

  localparam logic [1:0] EXP_ANY   = 2'd0;
  localparam logic [1:0] EXP_IOSEL = 2'd1;
  localparam logic [1:0] EXP_MASK  = 2'd2;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_INVALID = 2'd1;
  localparam logic [1:0] ST_REFUSED = 2'd2;

  localparam logic [7:0] IC_ENABLE   = 8'h80;
  localparam logic [7:0] IC_HIGHAND  = 8'h60;
  localparam logic [7:0] IC_AND      = 8'h40;
  localparam logic [7:0] IC_HIGH     = 8'h20;
  localparam logic [7:0] IC_READ_A   = 8'hC0;
  localparam logic [7:0] IC_WORD     = 8'hF0;
  localparam logic [3:0] CW_MODE     = 4'hF;
  localparam logic [3:0] CW_IC       = 4'h7;
  localparam logic [3:0] CW_EN_ONLY  = 4'h3;
  localparam int         CW_MASK_FOLLOWS_BIT = 4;

  typedef struct packed {
    logic [2:0] kind;
    logic       port_sel;
    logic [7:0] wdata;
    logic [7:0] pin_in;
  } pio_in_t;

  typedef struct packed {
    logic [7:0] rdata;
    logic [7:0] pin_out;
    logic       pin_out_valid;
    logic       rdy_level;
    logic       rdy_pulse;
    logic       irq;
    logic [7:0] irq_vector;
    logic [1:0] status;
  } pio_out_t;

  typedef struct packed {
    logic [7:0] out_latch;
    logic [7:0] in_latch;
    logic [1:0] port_mode;
    logic [7:0] irq_mask;
    logic [7:0] irq_ctrl;
    logic [7:0] dir_select;
    logic [1:0] expect_next;
    logic [7:0] vector_reg;
    logic       ready_flag;
    logic       match_flag;
  } port_state_t;

  localparam port_state_t PORT_RESET = '{
    out_latch:   8'h00,
    in_latch:    8'h00,
    port_mode:   MODE_IN,
    irq_mask:    8'hFF,
    irq_ctrl:    8'h00,
    dir_select:  8'h00,
    expect_next: EXP_ANY,
    vector_reg:  8'h00,
    ready_flag:  1'b0,
    match_flag:  1'b0
  };

endpackage

### hw/rtl/pio_access.sv
// Combinational access logic: next state of the addressed port and the result beat.
// Depends on pio_pkg.
module pio_access (
  input  pio_pkg::pio_in_t     item,
  input  pio_pkg::port_state_t port_a,
  input  pio_pkg::port_state_t port_b,
  output pio_pkg::port_state_t nxt,
  output pio_pkg::pio_out_t    res
);
  import pio_pkg::*;

  port_state_t cur;
  logic [7:0]  wd;
  logic [1:0]  new_mode;
  logic [7:0]  mixed;
  logic [7:0]  mask_n;
  logic [7:0]  val;
  logic [7:0]  ic_sel;
  logic        match;

  assign cur      = item.port_sel ? port_b : port_a;
  assign wd       = item.wdata;
  assign new_mode = wd[7:6];
  assign mixed    = (wd & cur.dir_select) | (cur.out_latch & ~cur.dir_select);
  assign mask_n   = ~cur.irq_mask;
  assign val      = mixed & mask_n;
  assign ic_sel   = cur.irq_ctrl & IC_HIGHAND;

  always_comb begin
    case (ic_sel)
      8'h00:   match = (val != mask_n);
      IC_HIGH: match = (val != 8'h00);
      IC_AND:  match = (val == 8'h00);
      default: match = (val == mask_n);
    endcase
  end

  always_comb begin
    nxt = cur;
    res = '0;
    case (item.kind)
      KIND_CTRL_WR: begin
        if (cur.expect_next == EXP_IOSEL) begin
          nxt.dir_select  = wd;
          nxt.expect_next = EXP_ANY;
        end else if (cur.expect_next == EXP_MASK) begin
          nxt.irq_mask    = wd;
          nxt.expect_next = EXP_ANY;
        end else if (!wd[0]) begin
          nxt.vector_reg = wd;
        end else if (wd[3:0] == CW_MODE) begin
          if (item.port_sel && new_mode == MODE_BIDIR) begin
            res.status = ST_REFUSED;
          end else begin
            nxt.port_mode = new_mode;
            if (new_mode == MODE_BITCTL) begin
              nxt.expect_next = EXP_IOSEL;
              nxt.match_flag  = 1'b0;
            end
          end
        end else if (wd[3:0] == CW_IC) begin
          nxt.irq_ctrl = wd & IC_WORD;
          if (wd[CW_MASK_FOLLOWS_BIT]) begin
            nxt.expect_next = EXP_MASK;
            nxt.match_flag  = 1'b0;
          end
        end else if (wd[3:0] == CW_EN_ONLY) begin
          nxt.irq_ctrl = (wd & IC_ENABLE) | (cur.irq_ctrl & ~IC_ENABLE);
        end else begin
          res.status = ST_INVALID;
        end
      end
      KIND_CTRL_RD: begin
        res.rdata = (port_a.irq_ctrl & IC_READ_A) | (port_b.irq_ctrl >> 4);
      end
      KIND_DATA_WR: begin
        nxt.out_latch = wd;
        if (cur.port_mode == MODE_OUT || cur.port_mode == MODE_BIDIR) begin
          res.pin_out       = wd;
          res.pin_out_valid = 1'b1;
          res.rdy_pulse     = cur.ready_flag;
          nxt.ready_flag    = 1'b1;
        end else if (cur.port_mode == MODE_BITCTL) begin
          res.pin_out       = cur.dir_select | (wd & ~cur.dir_select);
          res.pin_out_valid = 1'b1;
        end
      end
      KIND_DATA_RD: begin
        case (cur.port_mode)
          MODE_OUT: begin
            res.rdata = cur.out_latch;
          end
          MODE_IN: begin
            nxt.in_latch   = item.pin_in;
            res.rdata      = item.pin_in;
            res.rdy_pulse  = cur.ready_flag;
            nxt.ready_flag = 1'b1;
          end
          MODE_BIDIR: begin
            res.rdata      = cur.in_latch;
            res.rdy_pulse  = cur.ready_flag;
            nxt.ready_flag = 1'b1;
          end
          default: begin
            nxt.in_latch = item.pin_in;
            res.rdata    = (item.pin_in & cur.dir_select)
                         | (cur.out_latch & ~cur.dir_select);
          end
        endcase
      end
      KIND_PIN_UPD: begin
        if (cur.port_mode == MODE_BITCTL) begin
          nxt.in_latch = wd;
          if (!cur.match_flag && match && (cur.irq_ctrl & IC_ENABLE) != 8'h00) begin
            res.irq        = 1'b1;
            res.irq_vector = cur.vector_reg;
          end
          nxt.match_flag = match;
        end
      end
      default: begin
      end
    endcase
    res.rdy_level = nxt.ready_flag;
  end

endmodule

### hw/rtl/parallel_io_port_controller_unit.sv
// Top level of the two-port parallel I/O controller: input register, port state, result register.
// Depends on pio_pkg and pio_access.
//
// The block takes one access beat per cycle while no stall holds it and returns one result beat
// for each: the beat is captured in an input register, evaluated against the addressed
// port's registers in one pass of pio_access, and the result and the port's new state are
// written at the same edge. The next access therefore always sees the state left by the one
// before it. A stalled result holds its register; the input register keeps accepting as long
// as the result register is free or is being taken in the same cycle.
module parallel_io_port_controller_unit (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_stall,
  input  pio_pkg::pio_in_t  req,
  output logic              rsp_valid,
  input  logic              rsp_stall,
  output pio_pkg::pio_out_t rsp
);
  import pio_pkg::*;

  logic        item_valid;
  pio_in_t     item;
  port_state_t ports [PortCount];
  port_state_t port_next;
  pio_out_t    res_next;
  logic        res_free;
  logic        advance;

  assign res_free  = !rsp_valid || !rsp_stall;
  assign advance   = item_valid && res_free;
  assign req_stall = item_valid && !res_free;

  pio_access u_access (
    .item   (item),
    .port_a (ports[0]),
    .port_b (ports[1]),
    .nxt    (port_next),
    .res    (res_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      item_valid <= 1'b0;
    end else if (!req_stall) begin
      item_valid <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && !req_stall) begin
      item <= req;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= res_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < PortCount; i++) begin
        ports[i] <= PORT_RESET;
      end
    end else if (advance) begin
      ports[item.port_sel] <= port_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst) advance |=> rsp_valid)
    else $error("Evaluated access did not produce a result beat.");

  assert property (@(posedge clk) disable iff (rst)
    advance && res_next.irq |=> ports[$past(item.port_sel)].match_flag)
    else $error("Interrupt raised without the match flag being set.");

  assert property (@(posedge clk) disable iff (rst) ports[1].port_mode != MODE_BIDIR)
    else $error("Port B entered bidirectional mode.");

  assert property (@(posedge clk)
    rst |=> !rsp_valid && ports[0].port_mode == MODE_IN && ports[1].port_mode == MODE_IN)
    else $error("Reset did not return the ports to input mode.");

  assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp.irq |-> !rsp.pin_out_valid && rsp.rdata == 8'h00)
    else $error("Interrupt result carries data of another access type.");

endmodule
